>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the decimal parse block.
// No dependencies; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, muted while reset is asserted.
`define DPS_ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("dps assertion failed");

// Clocked check that also holds during reset.
`define DPS_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("dps assertion failed");

`else

`define DPS_ASSERT_CLK(lbl, clk_s, rstn_s, prop)
`define DPS_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

>>> rtl/dps_pkg.sv
// Shared types, constants and decode helpers for the decimal parse block.
// No dependencies.
package dps_pkg;

  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int SHAMT_W  = 7;

  localparam logic [VALUE_W-1:0] LIM_DIV = 64'h1999_9999_9999_9999; // (2^64-1)/10
  localparam logic [3:0]         LIM_REM = 4'd5;                    // (2^64-1)%10

  localparam logic SUFFIX_MODE_RST = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO = "0";
  localparam logic [CHAR_W-1:0] CH_NINE = "9";
  localparam logic [CHAR_W-1:0] CH_KILO = "k";
  localparam logic [CHAR_W-1:0] CH_MEGA = "M";
  localparam logic [CHAR_W-1:0] CH_GIGA = "G";
  localparam logic [CHAR_W-1:0] CH_TERA = "T";
  localparam logic [CHAR_W-1:0] CH_PETA = "P";
  localparam logic [CHAR_W-1:0] CH_EXA  = "E";
  localparam logic [CHAR_W-1:0] CH_ZETA = "Z";
  localparam logic [CHAR_W-1:0] CH_YOTA = "Y";

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value;
  } dps_result_t;

  // Left shift for a scale letter; zero when the byte is not one.
  function automatic logic [SHAMT_W-1:0] scale_shift(input logic [CHAR_W-1:0] c);
    logic [SHAMT_W-1:0] sh;
    unique case (c)
      CH_KILO: sh = 7'd10;
      CH_MEGA: sh = 7'd20;
      CH_GIGA: sh = 7'd30;
      CH_TERA: sh = 7'd40;
      CH_PETA: sh = 7'd50;
      CH_EXA:  sh = 7'd60;
      CH_ZETA: sh = 7'd70;
      CH_YOTA: sh = 7'd80;
      default: sh = '0;
    endcase
    return sh;
  endfunction

endpackage

>>> rtl/dps_in_reg.sv
// Input register for the decimal parse block: holds one byte word.
// Depends on dps_pkg.
module dps_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dps_pkg::CHAR_W-1:0] in_tdata,
  input  logic                       consume,
  output logic                       item_valid,
  output logic [dps_pkg::CHAR_W-1:0] item_char
);
  import dps_pkg::*;

  logic              valid_r;
  logic [CHAR_W-1:0] char_r;

  assign in_tready  = !valid_r || consume;
  assign item_valid = valid_r;
  assign item_char  = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (consume) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
    end
  end

endmodule

>>> rtl/dps_engine.sv
// Per-byte parse step: running value, skip flag and result decision.
// Depends on dps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dps_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  logic [dps_pkg::CHAR_W-1:0]  item_char,
  input  logic                        suffix_mode,
  input  logic                        out_room,
  output logic                        consume,
  output logic                        emit,
  output dps_pkg::dps_result_t        result
);
  import dps_pkg::*;

  logic [VALUE_W-1:0] accum_r, accum_nxt;
  logic               skipping_r, skipping_nxt;

  logic               emit_want;
  logic               is_digit;
  logic [3:0]         digit;
  logic               digit_ok;
  logic [VALUE_W-1:0] times_ten;
  logic [SHAMT_W-1:0] shamt;
  logic [VALUE_W-1:0] high_part;
  logic               scale_ovf;

  assign is_digit  = (item_char >= CH_ZERO) && (item_char <= CH_NINE);
  assign digit     = 4'(item_char - CH_ZERO);
  assign digit_ok  = (accum_r < LIM_DIV) || ((accum_r == LIM_DIV) && (digit <= LIM_REM));
  assign times_ten = (accum_r << 3) + (accum_r << 1) + VALUE_W'(digit);

  assign shamt     = scale_shift(item_char);
  // bits that would fall off the top; shifts of 64 or more always overflow
  assign high_part = accum_r >> (7'(VALUE_W) - shamt);
  assign scale_ovf = shamt[SHAMT_W-1] || (high_part != '0);

  always_comb begin
    emit_want     = 1'b0;
    result.value  = '0;
    result.status = ST_OK;
    accum_nxt     = accum_r;
    skipping_nxt  = skipping_r;
    if (skipping_r) begin
      if (item_char == CH_NUL) begin
        skipping_nxt = 1'b0;
        accum_nxt    = '0;
      end
    end else if (is_digit) begin
      if (digit_ok) begin
        accum_nxt = times_ten;
      end else begin
        emit_want     = 1'b1;
        result.status = ST_OVERFLOW;
        accum_nxt     = '0;
        skipping_nxt  = 1'b1;
      end
    end else if (item_char == CH_NUL) begin
      emit_want    = 1'b1;
      result.value = accum_r;
      accum_nxt    = '0;
    end else if (suffix_mode && (shamt != '0)) begin
      emit_want    = 1'b1;
      accum_nxt    = '0;
      skipping_nxt = 1'b1;
      if (scale_ovf) begin
        result.status = ST_OVERFLOW;
      end else begin
        result.value = accum_r << shamt;
      end
    end else begin
      emit_want     = 1'b1;
      result.status = ST_INVALID;
      accum_nxt     = '0;
      skipping_nxt  = 1'b1;
    end
  end

  // a byte that yields a result waits until the output register has room
  assign consume = item_valid && (!emit_want || out_room);
  assign emit    = consume && emit_want;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r    <= '0;
      skipping_r <= 1'b0;
    end else if (consume) begin
      accum_r    <= accum_nxt;
      skipping_r <= skipping_nxt;
    end
  end

  `DPS_ASSERT_CLK(a_no_emit_without_room, clk, rst_n, emit |-> out_room)
  `DPS_ASSERT_CLK(a_accum_clear_after_emit, clk, rst_n, emit |=> (accum_r == '0))
  `DPS_ASSERT_CLK(a_skip_is_silent, clk, rst_n, skipping_r |-> !emit_want)
  `DPS_ASSERT_CLK(a_bad_status_zero_value, clk, rst_n,
                  (emit_want && (result.status != ST_OK)) |-> (result.value == '0))

endmodule

>>> rtl/dps_out_reg.sv
// Result register for the decimal parse block, drives the master side.
// Depends on dps_pkg.
module dps_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  dps_pkg::dps_result_t  result,
  output logic                  room,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata
);
  import dps_pkg::*;

  logic        valid_r;
  dps_result_t res_r;

  assign room       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {6'b0, res_r.status, res_r.value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule

>>> rtl/decimal_parse_binary_suffix_unit.sv
// Top level of the decimal string parser with binary scale suffixes.
// Depends on dps_pkg, dps_in_reg, dps_engine, dps_out_reg.
//
//   channel  dir  handshake                 payload
//   in_      in   in_tvalid / in_tready     in_tdata[7:0] = char_in
//   out_     out  out_tvalid / out_tready   out_tdata[63:0] value, [65:64] status
//   cfg_     in   cfg_wr_en                 cfg_wr_data = suffix_mode
//
// One byte word per cycle sustained while out_ takes results. A word waits in
// the input register; its result, if any, is loaded into the result register.
// The cycle time is set by the times-ten add and the 64-bit limit compare.
// rst_n is synchronous, active low: value 0, not skipping, suffix_mode 1.
// A stall on out_ blocks only words that produce a result; others keep flowing.
module decimal_parse_binary_suffix_unit (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_in
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [63:0] value, [65:64] status, [71:66] zero
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data  // suffix_mode
);
  import dps_pkg::*;

  logic              suffix_mode_r;
  logic              item_valid;
  logic [CHAR_W-1:0] item_char;
  logic              consume;
  logic              emit;
  logic              room;
  dps_result_t       result;

  // mode register; the user must write it only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      suffix_mode_r <= SUFFIX_MODE_RST;
    end else if (cfg_wr_en) begin
      suffix_mode_r <= cfg_wr_data;
    end
  end

  dps_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .consume    (consume),
    .item_valid (item_valid),
    .item_char  (item_char)
  );

  // parse step: digits accumulate, the first non-digit decides the word
  dps_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_char   (item_char),
    .suffix_mode (suffix_mode_r),
    .out_room    (room),
    .consume     (consume),
    .emit        (emit),
    .result      (result)
  );

  dps_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .result     (result),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
